// ===== rtl/v3au_pkg.sv =====
// Shared types, constants and arithmetic helpers for the 3D vector arithmetic unit.
package v3au_pkg;

	localparam int DW = 32;
	localparam int FB = 16;
	localparam int PW = 2 * DW;
	localparam int NMUL = 6;
	localparam int NITER = DW + FB;
	localparam int NSQRT = DW;
	localparam int REMW = DW + 4;
	localparam int ITER_FIRST = 6;
	localparam int PIPE_DEPTH = ITER_FIRST + NITER + 5;

	localparam logic signed [DW-1:0] QMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] QMIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] EQ_ONE = {{(DW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};
	localparam logic signed [PW-1:0] HALF_LSB = {{(PW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};

	typedef enum logic [3:0] {
		OP_ADD    = 4'd0,
		OP_SUB    = 4'd1,
		OP_SCALE  = 4'd2,
		OP_COMP   = 4'd3,
		OP_DOT    = 4'd4,
		OP_CROSS  = 4'd5,
		OP_NORM   = 4'd6,
		OP_PROJ   = 4'd7,
		OP_DIST   = 4'd8,
		OP_TRIPLE = 4'd9,
		OP_EQUAL  = 4'd10
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SAT      = 2'd1,
		ST_ZERO_DIV = 2'd2
	} status_t;

	// One pipeline slot. Fields are reused from stage to stage.
	typedef struct packed {
		logic [3:0]             op;
		logic [2:0][DW-1:0]     a;
		logic [2:0][DW-1:0]     b;
		logic [2:0][DW-1:0]     c;
		logic [DW-1:0]          k;
		logic [NMUL-1:0][DW-1:0] ml;
		logic [NMUL-1:0][DW-1:0] mr;
		logic [NMUL-1:0][PW-1:0] p;
		logic [2:0][DW-1:0]     r;
		logic [DW-1:0]          s;
		logic                   flg;
		logic                   zdiv;
		logic                   big;
		logic                   neg;
		logic [DW-1:0]          ndiv;
		logic [REMW-1:0]        rem;
		logic [PW-1:0]          sh;
		logic [NITER-1:0]       res;
		status_t                st;
	} pipe_t;

	// Saturate to DW bits; the top bit of the result flags an overflow.
	function automatic logic [DW:0] sat_fn(input logic signed [PW-1:0] v);
		logic [DW:0] o;
		if (v > PW'(QMAX)) begin
			o = {1'b1, QMAX};
		end else if (v < PW'(QMIN)) begin
			o = {1'b1, QMIN};
		end else begin
			o = {1'b0, v[DW-1:0]};
		end
		return o;
	endfunction

	function automatic logic [PW-1:0] mul_fn(input logic signed [DW-1:0] x,
			input logic signed [DW-1:0] y);
		logic signed [PW-1:0] m;
		m = x * y;
		return m;
	endfunction

	// Round a full product to FB fraction bits: add half an LSB, shift arithmetically.
	function automatic logic [PW-1:0] rnd_fn(input logic signed [PW-1:0] x);
		logic signed [PW-1:0] t;
		t = x + HALF_LSB;
		return t >>> FB;
	endfunction

endpackage

// ===== rtl/vector3_arithmetic_unit.sv =====
// Throughput: one item per cycle while the result is not stalled; the longest column is the
// 48-step shared divide/square-root unit, one quotient or root bit per pipeline stage.
// A stalled result holds only the stages behind it that are full; bubbles still close up.
// Reset (arst_n, asynchronous, active low) clears the valid bits; data registers keep
// whatever they hold and are never looked at while invalid.
module vector3_arithmetic_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        stall,
	input  logic [3:0]  opcode,
	input  logic [31:0] a_x,
	input  logic [31:0] a_y,
	input  logic [31:0] a_z,
	input  logic [31:0] b_x,
	input  logic [31:0] b_y,
	input  logic [31:0] b_z,
	input  logic [31:0] c_x,
	input  logic [31:0] c_y,
	input  logic [31:0] c_z,
	input  logic [31:0] scale_factor,
	output logic        r_valid,
	input  logic        r_stall,
	output logic [31:0] r_x,
	output logic [31:0] r_y,
	output logic [31:0] r_z,
	output logic [31:0] scalar_out,
	output logic [1:0]  status
);

	localparam int D = v3au_pkg::PIPE_DEPTH;
	localparam int IF = v3au_pkg::ITER_FIRST;
	localparam int IL = v3au_pkg::ITER_FIRST + v3au_pkg::NITER;

	v3au_pkg::pipe_t pipe_s [D];
	v3au_pkg::pipe_t nxt    [D];
	logic [D-1:0]    vld_s;
	logic [D-1:0]    go;

	// A stage moves on unless it and every stage ahead of it are full while the
	// result is stalled. Each enable is a plain AND reduction, not a ripple.
	for (genvar k = 0; k < D; k++) begin : g_go
		assign go[k] = !r_stall || !(&vld_s[D-1:k]);
	end

	assign stall = !go[0];

	// Stage 1 captures the input transfer.
	always_comb begin : c_s1
		nxt[0]       = '0;
		nxt[0].op    = opcode;
		nxt[0].a[0]  = a_x;
		nxt[0].a[1]  = a_y;
		nxt[0].a[2]  = a_z;
		nxt[0].b[0]  = b_x;
		nxt[0].b[1]  = b_y;
		nxt[0].b[2]  = b_z;
		nxt[0].c[0]  = c_x;
		nxt[0].c[1]  = c_y;
		nxt[0].c[2]  = c_z;
		nxt[0].k     = scale_factor;
	end

	// Stage 2: sums and differences, equality, multiplier operand selection.
	always_comb begin : c_s2
		v3au_pkg::pipe_t t;
		logic signed [v3au_pkg::DW:0] sa [3];
		logic signed [v3au_pkg::DW:0] sd [3];
		logic [2:0][v3au_pkg::DW-1:0] u;
		logic [2:0][v3au_pkg::DW-1:0] v;
		logic [v3au_pkg::DW:0] sv;
		t = pipe_s[0];
		u = (t.op == v3au_pkg::OP_CROSS) ? t.a : t.b;
		v = (t.op == v3au_pkg::OP_CROSS) ? t.b : t.c;
		sv = '0;
		for (int i = 0; i < 3; i++) begin
			sa[i] = {t.a[i][v3au_pkg::DW-1], t.a[i]} + {t.b[i][v3au_pkg::DW-1], t.b[i]};
			sd[i] = {t.a[i][v3au_pkg::DW-1], t.a[i]} - {t.b[i][v3au_pkg::DW-1], t.b[i]};
		end
		case (t.op)
			v3au_pkg::OP_ADD: begin
				for (int i = 0; i < 3; i++) begin
					sv = v3au_pkg::sat_fn(v3au_pkg::PW'(sa[i]));
					t.r[i] = sv[v3au_pkg::DW-1:0];
					t.flg = t.flg | sv[v3au_pkg::DW];
				end
			end
			v3au_pkg::OP_SUB: begin
				for (int i = 0; i < 3; i++) begin
					sv = v3au_pkg::sat_fn(v3au_pkg::PW'(sd[i]));
					t.r[i] = sv[v3au_pkg::DW-1:0];
					t.flg = t.flg | sv[v3au_pkg::DW];
				end
			end
			v3au_pkg::OP_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					t.ml[i] = t.a[i];
					t.mr[i] = t.k;
				end
			end
			v3au_pkg::OP_COMP, v3au_pkg::OP_DOT: begin
				for (int i = 0; i < 3; i++) begin
					t.ml[i] = t.a[i];
					t.mr[i] = t.b[i];
				end
			end
			v3au_pkg::OP_CROSS, v3au_pkg::OP_TRIPLE: begin
				t.ml[0] = u[1]; t.mr[0] = v[2];
				t.ml[1] = u[2]; t.mr[1] = v[1];
				t.ml[2] = u[2]; t.mr[2] = v[0];
				t.ml[3] = u[0]; t.mr[3] = v[2];
				t.ml[4] = u[0]; t.mr[4] = v[1];
				t.ml[5] = u[1]; t.mr[5] = v[0];
			end
			v3au_pkg::OP_NORM: begin
				for (int i = 0; i < 3; i++) begin
					t.ml[i] = t.a[i];
					t.mr[i] = t.a[i];
				end
			end
			v3au_pkg::OP_PROJ: begin
				for (int i = 0; i < 3; i++) begin
					t.ml[i]   = t.a[i];
					t.mr[i]   = t.b[i];
					t.ml[3+i] = t.b[i];
					t.mr[3+i] = t.b[i];
				end
			end
			v3au_pkg::OP_DIST: begin
				for (int i = 0; i < 3; i++) begin
					// The most negative value counts as out of range, like anything wider.
					if (v3au_pkg::PW'(sd[i]) > v3au_pkg::PW'(v3au_pkg::QMAX) ||
							v3au_pkg::PW'(sd[i]) < -v3au_pkg::PW'(v3au_pkg::QMAX)) begin
						t.big = 1'b1;
					end
					t.ml[i] = sd[i][v3au_pkg::DW-1:0];
					t.mr[i] = sd[i][v3au_pkg::DW-1:0];
				end
			end
			v3au_pkg::OP_EQUAL: begin
				t.s = (t.a == t.b) ? v3au_pkg::EQ_ONE : '0;
			end
			default: begin
			end
		endcase
		nxt[1] = t;
	end

	// Stage 3: six 32 x 32 multipliers.
	always_comb begin : c_s3
		v3au_pkg::pipe_t t;
		t = pipe_s[1];
		for (int j = 0; j < v3au_pkg::NMUL; j++) begin
			t.p[j] = v3au_pkg::mul_fn(t.ml[j], t.mr[j]);
		end
		nxt[2] = t;
	end

	// Stage 4: rounding. Squares for norm and distance stay exact.
	always_comb begin : c_s4
		v3au_pkg::pipe_t t;
		t = pipe_s[2];
		if (t.op != v3au_pkg::OP_NORM && t.op != v3au_pkg::OP_DIST) begin
			for (int j = 0; j < v3au_pkg::NMUL; j++) begin
				t.p[j] = v3au_pkg::rnd_fn($signed(t.p[j]));
			end
		end
		nxt[3] = t;
	end

	// Stage 5: dot sums, cross differences, sum of squares.
	always_comb begin : c_s5
		v3au_pkg::pipe_t q;
		v3au_pkg::pipe_t t;
		q = pipe_s[3];
		t = q;
		case (q.op)
			v3au_pkg::OP_DOT, v3au_pkg::OP_PROJ: begin
				t.p[0] = q.p[0] + q.p[1] + q.p[2];
				t.p[1] = q.p[3] + q.p[4] + q.p[5];
			end
			v3au_pkg::OP_CROSS, v3au_pkg::OP_TRIPLE: begin
				t.p[0] = q.p[0] - q.p[1];
				t.p[1] = q.p[2] - q.p[3];
				t.p[2] = q.p[4] - q.p[5];
			end
			v3au_pkg::OP_NORM, v3au_pkg::OP_DIST: begin
				t.sh = q.p[0] + q.p[1] + q.p[2];
			end
			default: begin
			end
		endcase
		nxt[4] = t;
	end

	// Stage 6: saturation, and setup of the divider for projection.
	always_comb begin : c_s6
		v3au_pkg::pipe_t t;
		logic [v3au_pkg::DW:0] sv;
		logic [v3au_pkg::DW:0] nv;
		logic [v3au_pkg::DW-1:0] mag;
		t = pipe_s[4];
		sv = '0;
		nv = '0;
		mag = '0;
		case (t.op)
			v3au_pkg::OP_SCALE, v3au_pkg::OP_COMP, v3au_pkg::OP_CROSS,
			v3au_pkg::OP_TRIPLE: begin
				for (int i = 0; i < 3; i++) begin
					sv = v3au_pkg::sat_fn($signed(t.p[i]));
					t.r[i] = sv[v3au_pkg::DW-1:0];
					t.flg = t.flg | sv[v3au_pkg::DW];
				end
			end
			v3au_pkg::OP_DOT: begin
				sv = v3au_pkg::sat_fn($signed(t.p[0]));
				t.s = sv[v3au_pkg::DW-1:0];
				t.flg = t.flg | sv[v3au_pkg::DW];
			end
			v3au_pkg::OP_PROJ: begin
				sv = v3au_pkg::sat_fn($signed(t.p[0]));
				nv = v3au_pkg::sat_fn($signed(t.p[1]));
				t.flg = t.flg | sv[v3au_pkg::DW] | nv[v3au_pkg::DW];
				t.neg = sv[v3au_pkg::DW-1];
				mag = t.neg ? (~sv[v3au_pkg::DW-1:0] + 1'b1) : sv[v3au_pkg::DW-1:0];
				t.zdiv = ($signed(nv[v3au_pkg::DW-1:0]) <= 0);
				t.ndiv = nv[v3au_pkg::DW-1:0];
				t.sh = {mag, {(v3au_pkg::PW-v3au_pkg::DW){1'b0}}};
			end
			default: begin
			end
		endcase
		nxt[5] = t;
	end

	// Shared restoring unit: one quotient bit per stage for projection, one root
	// bit per stage over the first stages for norm and distance.
	for (genvar j = 0; j < v3au_pkg::NITER; j++) begin : g_iter
		always_comb begin : c_iter
			v3au_pkg::pipe_t t;
			logic [v3au_pkg::REMW-1:0] cand;
			logic [v3au_pkg::REMW-1:0] trial;
			logic is_div;
			logic is_sqrt;
			logic hit;
			t = pipe_s[IF+j-1];
			is_div = (t.op == v3au_pkg::OP_PROJ);
			is_sqrt = (t.op == v3au_pkg::OP_NORM || t.op == v3au_pkg::OP_DIST) &&
				(j < v3au_pkg::NSQRT);
			if (is_div) begin
				cand = {t.rem[v3au_pkg::REMW-2:0], t.sh[v3au_pkg::PW-1]};
				trial = v3au_pkg::REMW'(t.ndiv);
			end else begin
				cand = {t.rem[v3au_pkg::REMW-3:0], t.sh[v3au_pkg::PW-1:v3au_pkg::PW-2]};
				trial = v3au_pkg::REMW'({t.res[v3au_pkg::DW-1:0], 2'b01});
			end
			hit = (cand >= trial);
			if (is_div || is_sqrt) begin
				t.rem = hit ? (cand - trial) : cand;
				t.sh = is_div ? (t.sh << 1) : (t.sh << 2);
				t.res = {t.res[v3au_pkg::NITER-2:0], hit};
			end
			nxt[IF+j] = t;
		end
	end

	// Post stage: signed quotient, root saturation, second multiply operands.
	always_comb begin : c_post
		v3au_pkg::pipe_t t;
		logic signed [v3au_pkg::NITER:0] qv;
		logic [v3au_pkg::DW:0] sv;
		logic [v3au_pkg::DW-1:0] root;
		t = pipe_s[IL-1];
		qv = t.neg ? -$signed({1'b0, t.res}) : $signed({1'b0, t.res});
		sv = v3au_pkg::sat_fn(v3au_pkg::PW'(qv));
		root = t.res[v3au_pkg::DW-1:0];
		case (t.op)
			v3au_pkg::OP_PROJ: begin
				if (!t.zdiv) begin
					t.flg = t.flg | sv[v3au_pkg::DW];
					for (int i = 0; i < 3; i++) begin
						t.ml[i] = t.b[i];
						t.mr[i] = sv[v3au_pkg::DW-1:0];
					end
				end
			end
			v3au_pkg::OP_NORM, v3au_pkg::OP_DIST: begin
				if (t.big || root[v3au_pkg::DW-1]) begin
					t.s = v3au_pkg::QMAX;
					t.flg = 1'b1;
				end else begin
					t.s = root;
				end
			end
			v3au_pkg::OP_TRIPLE: begin
				for (int i = 0; i < 3; i++) begin
					t.ml[i] = t.a[i];
					t.mr[i] = t.r[i];
				end
			end
			default: begin
			end
		endcase
		nxt[IL] = t;
	end

	// Second multiply for projection and triple product.
	always_comb begin : c_mul2
		v3au_pkg::pipe_t t;
		t = pipe_s[IL];
		for (int i = 0; i < 3; i++) begin
			t.p[i] = v3au_pkg::mul_fn(t.ml[i], t.mr[i]);
		end
		nxt[IL+1] = t;
	end

	always_comb begin : c_rnd2
		v3au_pkg::pipe_t t;
		t = pipe_s[IL+1];
		for (int i = 0; i < 3; i++) begin
			t.p[i] = v3au_pkg::rnd_fn($signed(t.p[i]));
		end
		nxt[IL+2] = t;
	end

	always_comb begin : c_sum2
		v3au_pkg::pipe_t t;
		t = pipe_s[IL+2];
		if (t.op == v3au_pkg::OP_TRIPLE) begin
			t.p[0] = t.p[0] + t.p[1] + t.p[2];
		end
		nxt[IL+3] = t;
	end

	// Final stage: last saturation and status; this register drives the outputs.
	always_comb begin : c_fin
		v3au_pkg::pipe_t t;
		logic [v3au_pkg::DW:0] sv;
		t = pipe_s[IL+3];
		sv = '0;
		case (t.op)
			v3au_pkg::OP_PROJ: begin
				if (!t.zdiv) begin
					for (int i = 0; i < 3; i++) begin
						sv = v3au_pkg::sat_fn($signed(t.p[i]));
						t.r[i] = sv[v3au_pkg::DW-1:0];
						t.flg = t.flg | sv[v3au_pkg::DW];
					end
				end
			end
			v3au_pkg::OP_TRIPLE: begin
				sv = v3au_pkg::sat_fn($signed(t.p[0]));
				t.s = sv[v3au_pkg::DW-1:0];
				t.flg = t.flg | sv[v3au_pkg::DW];
				t.r = '0;
			end
			default: begin
			end
		endcase
		if (t.op == v3au_pkg::OP_PROJ && t.zdiv) begin
			t.st = v3au_pkg::ST_ZERO_DIV;
		end else if (t.flg) begin
			t.st = v3au_pkg::ST_SAT;
		end else begin
			t.st = v3au_pkg::ST_OK;
		end
		nxt[IL+4] = t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (go[0]) begin
				vld_s[0] <= valid;
			end
			for (int k = 1; k < D; k++) begin
				if (go[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < D; k++) begin
			if (go[k]) begin
				pipe_s[k] <= nxt[k];
			end
		end
	end

	assign r_valid    = vld_s[D-1];
	assign r_x        = pipe_s[D-1].r[0];
	assign r_y        = pipe_s[D-1].r[1];
	assign r_z        = pipe_s[D-1].r[2];
	assign scalar_out = pipe_s[D-1].s;
	assign status     = pipe_s[D-1].st;

	// The input is held off only when every stage holds an item.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		stall |-> (&vld_s))
		else $error("input stalled with a bubble in the pipeline");

	// An accepted transfer lands in the first stage.
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !stall) |=> vld_s[0])
		else $error("accepted transfer was lost at entry");

	// A zero divisor is reported only for projection, and with all values zero.
	a_zdiv: assert property (@(posedge clk) disable iff (!arst_n)
		(r_valid && status == v3au_pkg::ST_ZERO_DIV) |->
		(pipe_s[D-1].op == v3au_pkg::OP_PROJ && r_x == '0 && r_y == '0 &&
		r_z == '0 && scalar_out == '0))
		else $error("bad zero-divisor result");

	// Equality yields exactly 1.0 or 0.
	a_eq: assert property (@(posedge clk) disable iff (!arst_n)
		(r_valid && pipe_s[D-1].op == v3au_pkg::OP_EQUAL) |->
		(scalar_out == '0 || scalar_out == v3au_pkg::EQ_ONE))
		else $error("equality result not 1.0 or 0");

	// Scalar operations leave the vector result zero.
	a_svec: assert property (@(posedge clk) disable iff (!arst_n)
		(r_valid && (pipe_s[D-1].op == v3au_pkg::OP_DOT ||
		pipe_s[D-1].op == v3au_pkg::OP_NORM || pipe_s[D-1].op == v3au_pkg::OP_DIST ||
		pipe_s[D-1].op == v3au_pkg::OP_TRIPLE || pipe_s[D-1].op == v3au_pkg::OP_EQUAL))
		|-> (r_x == '0 && r_y == '0 && r_z == '0))
		else $error("scalar operation produced a nonzero vector");

endmodule

// ===== sim/v3au_checker.sv =====
// Result checker for the 3D vector arithmetic unit: it predicts each result and compares it.
`timescale 1ns / 100ps
module v3au_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	input  logic        stall,
	input  logic [3:0]  opcode,
	input  logic [31:0] a_x,
	input  logic [31:0] a_y,
	input  logic [31:0] a_z,
	input  logic [31:0] b_x,
	input  logic [31:0] b_y,
	input  logic [31:0] b_z,
	input  logic [31:0] c_x,
	input  logic [31:0] c_y,
	input  logic [31:0] c_z,
	input  logic [31:0] scale_factor,
	input  logic        r_valid,
	input  logic        r_stall,
	input  logic [31:0] r_x,
	input  logic [31:0] r_y,
	input  logic [31:0] r_z,
	input  logic [31:0] scalar_out,
	input  logic [1:0]  status,
	output int          fail_count,
	output int          pending
);

	typedef struct {
		logic [31:0]        x;
		logic [31:0]        y;
		logic [31:0]        z;
		logic [31:0]        s;
		v3au_pkg::status_t  st;
	} vec_result_t;

	localparam longint HI = 64'sd2147483647;
	localparam longint LO = -64'sd2147483648;

	vec_result_t expected_results[$];

	function automatic longint clamp(input longint v, inout bit f);
		if (v > HI) begin
			f = 1'b1;
			return HI;
		end
		if (v < LO) begin
			f = 1'b1;
			return LO;
		end
		return v;
	endfunction

	// Exact product rounded to 16 fraction bits; >>> on a signed longint floors.
	function automatic longint fxmul(input longint x, input longint y);
		return (x * y + 64'sd32768) >>> 16;
	endfunction

	function automatic longint unsigned square(input longint v);
		longint unsigned m;
		m = (v < 0) ? -v : v;
		return m * m;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned res;
		longint unsigned bt;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > n)
			bt = bt >> 2;
		while (bt != 0) begin
			if (n >= res + bt) begin
				n = n - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	function automatic vec_result_t vector_op(input logic [3:0] op,
			input longint a[3], input longint b[3], input longint c[3], input longint k);
		vec_result_t o;
		longint r[3];
		longint u[3];
		longint v[3];
		longint x[3];
		longint s, d, n, q;
		longint unsigned mag, root;
		bit f, big, zdiv;
		r = '{0, 0, 0};
		s = 0;
		f = 0;
		zdiv = 0;
		case (op)
			v3au_pkg::OP_ADD:   foreach (r[i]) r[i] = clamp(a[i] + b[i], f);
			v3au_pkg::OP_SUB:   foreach (r[i]) r[i] = clamp(a[i] - b[i], f);
			v3au_pkg::OP_SCALE: foreach (r[i]) r[i] = clamp(fxmul(a[i], k), f);
			v3au_pkg::OP_COMP:  foreach (r[i]) r[i] = clamp(fxmul(a[i], b[i]), f);
			v3au_pkg::OP_DOT:
				s = clamp(fxmul(a[0], b[0]) + fxmul(a[1], b[1]) + fxmul(a[2], b[2]), f);
			v3au_pkg::OP_CROSS, v3au_pkg::OP_TRIPLE: begin
				if (op == v3au_pkg::OP_CROSS) begin
					u = a;
					v = b;
				end else begin
					u = b;
					v = c;
				end
				x[0] = clamp(fxmul(u[1], v[2]) - fxmul(u[2], v[1]), f);
				x[1] = clamp(fxmul(u[2], v[0]) - fxmul(u[0], v[2]), f);
				x[2] = clamp(fxmul(u[0], v[1]) - fxmul(u[1], v[0]), f);
				if (op == v3au_pkg::OP_CROSS)
					r = x;
				else
					s = clamp(fxmul(a[0], x[0]) + fxmul(a[1], x[1]) + fxmul(a[2], x[2]), f);
			end
			v3au_pkg::OP_NORM: begin
				root = int_sqrt(square(a[0]) + square(a[1]) + square(a[2]));
				if (root > HI) begin
					f = 1;
					s = HI;
				end else begin
					s = root;
				end
			end
			v3au_pkg::OP_PROJ: begin
				d = clamp(fxmul(a[0], b[0]) + fxmul(a[1], b[1]) + fxmul(a[2], b[2]), f);
				n = clamp(fxmul(b[0], b[0]) + fxmul(b[1], b[1]) + fxmul(b[2], b[2]), f);
				if (n <= 0) begin
					zdiv = 1;
				end else begin
					mag = (d < 0) ? -d : d;
					q = (mag << 16) / longint'(n);
					if (d < 0)
						q = -q;
					q = clamp(q, f);
					foreach (r[i]) r[i] = clamp(fxmul(b[i], q), f);
				end
			end
			v3au_pkg::OP_DIST: begin
				big = 0;
				foreach (x[i]) begin
					x[i] = a[i] - b[i];
					if (x[i] > HI || x[i] < -HI)
						big = 1;
				end
				if (big) begin
					f = 1;
					s = HI;
				end else begin
					root = int_sqrt(square(x[0]) + square(x[1]) + square(x[2]));
					if (root > HI) begin
						f = 1;
						s = HI;
					end else begin
						s = root;
					end
				end
			end
			v3au_pkg::OP_EQUAL: s = (a == b) ? 64'sd65536 : 0;
			default: ;
		endcase
		o.x = r[0][31:0];
		o.y = r[1][31:0];
		o.z = r[2][31:0];
		o.s = s[31:0];
		o.st = zdiv ? v3au_pkg::ST_ZERO_DIV : (f ? v3au_pkg::ST_SAT : v3au_pkg::ST_OK);
		return o;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk) begin
		longint a[3], b[3], c[3];
		vec_result_t e;
		if (arst_n && valid && !stall) begin
			a = '{longint'($signed(a_x)), longint'($signed(a_y)), longint'($signed(a_z))};
			b = '{longint'($signed(b_x)), longint'($signed(b_y)), longint'($signed(b_z))};
			c = '{longint'($signed(c_x)), longint'($signed(c_y)), longint'($signed(c_z))};
			expected_results.push_back(vector_op(opcode, a, b, c,
				longint'($signed(scale_factor))));
		end
		if (arst_n && r_valid && !r_stall) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with no result expected");
				fail_count <= fail_count + 1;
			end else begin
				e = expected_results.pop_front();
				if (r_x !== e.x || r_y !== e.y || r_z !== e.z || scalar_out !== e.s
						|| status !== e.st) begin
					if (r_x !== e.x)
						$error("r_x expected %h got %h", e.x, r_x);
					if (r_y !== e.y)
						$error("r_y expected %h got %h", e.y, r_y);
					if (r_z !== e.z)
						$error("r_z expected %h got %h", e.z, r_z);
					if (scalar_out !== e.s)
						$error("scalar_out expected %h got %h", e.s, scalar_out);
					if (status !== e.st)
						$error("status expected %0d got %0d", e.st, status);
					fail_count <= fail_count + 1;
				end
			end
		end
	end

	initial fail_count = 0;

endmodule

// ===== sim/tb_vector3_arithmetic_unit.sv =====
// Testbench top for the 3D vector arithmetic unit: stimulus, stalls, watchdog and verdict.
`timescale 1ns / 100ps
module tb_vector3_arithmetic_unit;

	// Cycles with no transfer on either channel before the run is declared hung.
	// The longest quiet stretch lies within the forced receiver hold-off.
	localparam int HANG_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 185;

	logic        clk;
	logic        arst_n;
	logic        valid;
	logic        stall;
	logic [3:0]  opcode;
	logic [31:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, scale_factor;
	logic        r_valid;
	logic        r_stall;
	logic [31:0] r_x, r_y, r_z, scalar_out;
	logic [1:0]  status;

	int fail_count;
	int pending;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_request;
	int quiet_cycles;

	vector3_arithmetic_unit dut (.*);

	v3au_checker checker_i (.*);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Receiver side. The stall pattern follows the current phase, except for one
	// long hold-off that makes the pipeline fill and push back on the sender.
	initial begin
		int hold_left;
		bit hold_taken;
		hold_left = 0;
		hold_taken = 0;
		r_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				r_stall = 1'b1;
			end else if (hold_request && !hold_taken) begin
				hold_taken = 1;
				hold_left = HOLD_CYCLES - 1;
				r_stall = 1'b1;
			end else begin
				r_stall = ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Watchdog: any transfer on either side restarts the count.
	always @(posedge clk) begin
		if ((valid && !stall) || (r_valid && !r_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == HANG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// A component value: mostly moderate magnitudes so that the arithmetic stays
	// in range, with extremes and fully random words mixed in for saturation.
	function automatic logic [31:0] pick_q();
		int sel;
		sel = $urandom_range(9);
		case (sel)
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(255) - 128;
			3, 4: return $urandom();
			default: return 32'($signed($urandom_range(32'h000fffff))) - 32'sh00080000;
		endcase
	endfunction

	// One input transfer: fields change at the falling edge and valid stays high
	// until the unit takes the item. A gap may follow, set by the phase.
	task automatic offer(input logic [3:0] op, input logic [31:0] ax, ay, az,
			bx, by, bz, cx, cy, cz, k);
		@(negedge clk);
		opcode = op;
		{a_x, a_y, a_z} = {ax, ay, az};
		{b_x, b_y, b_z} = {bx, by, bz};
		{c_x, c_y, c_z} = {cx, cy, cz};
		scale_factor = k;
		valid = 1'b1;
		do @(posedge clk); while (stall);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			valid = 1'b0;
			opcode = $urandom();
			a_x = $urandom();
		end
	endtask

	task automatic offer_random();
		logic [3:0] op;
		logic [31:0] ax, ay, az, bx, by, bz, cx, cy, cz, k;
		op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 11)) : 4'($urandom_range(10));
		ax = pick_q(); ay = pick_q(); az = pick_q();
		bx = pick_q(); by = pick_q(); bz = pick_q();
		cx = pick_q(); cy = pick_q(); cz = pick_q();
		k = pick_q();
		case ($urandom_range(7))
			// Equal operands, for the equality test and zero differences.
			0: {bx, by, bz} = {ax, ay, az};
			// A second vector so short that its rounded self dot product is zero.
			1: begin
				bx = $urandom_range(200) - 100;
				by = $urandom_range(200) - 100;
				bz = $urandom_range(200) - 100;
			end
			2: {bx, by, bz} = '0;
			default: ;
		endcase
		offer(op, ax, ay, az, bx, by, bz, cx, cy, cz, k);
	endtask

	task automatic drain();
		@(negedge clk);
		valid = 1'b0;
		wait (pending == 0);
	endtask

	initial begin
		valid = 1'b0;
		opcode = '0;
		{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, scale_factor} = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed items: every operation, extremes of the fields, and the special cases.
		offer(v3au_pkg::OP_ADD, 32'h7fffffff, 32'h80000000, 32'h00010000,
			32'h00000001, 32'hffffffff, 32'h00020000, '0, '0, '0, '0);
		offer(v3au_pkg::OP_SUB, 32'h80000000, 32'h7fffffff, 32'h00030000,
			32'h00000001, 32'hffffffff, 32'h00010000, '0, '0, '0, '0);
		offer(v3au_pkg::OP_SCALE, 32'h00018000, 32'hfffe0000, 32'h7fffffff,
			'0, '0, '0, '0, '0, '0, 32'h00020000);
		offer(v3au_pkg::OP_SCALE, 32'h80000000, 32'h80000000, 32'h00000001,
			'0, '0, '0, '0, '0, '0, 32'h80000000);
		offer(v3au_pkg::OP_COMP, 32'h00020000, 32'h7fffffff, 32'h00008000,
			32'h00030000, 32'h7fffffff, 32'hffff8000, '0, '0, '0, '0);
		offer(v3au_pkg::OP_DOT, 32'h00010000, 32'h00020000, 32'h00030000,
			32'h00040000, 32'h00050000, 32'h00060000, '0, '0, '0, '0);
		offer(v3au_pkg::OP_DOT, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, '0, '0, '0, '0);
		offer(v3au_pkg::OP_CROSS, 32'h00010000, '0, '0, '0, 32'h00010000, '0,
			'0, '0, '0, '0);
		offer(v3au_pkg::OP_CROSS, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h80000000, 32'h7fffffff, '0, '0, '0, '0);
		offer(v3au_pkg::OP_NORM, 32'h00030000, 32'h00040000, '0, '0, '0, '0,
			'0, '0, '0, '0);
		// Norm of the most negative components is past the top of the range.
		offer(v3au_pkg::OP_NORM, 32'h80000000, 32'h80000000, 32'h80000000,
			'0, '0, '0, '0, '0, '0, '0);
		offer(v3au_pkg::OP_PROJ, 32'h00020000, 32'h00010000, '0,
			32'h00010000, '0, '0, '0, '0, '0, '0);
		// Projection onto the zero vector, and onto one whose square rounds to zero.
		offer(v3au_pkg::OP_PROJ, 32'h00050000, 32'h00010000, 32'h00020000,
			'0, '0, '0, '0, '0, '0, '0);
		offer(v3au_pkg::OP_PROJ, 32'h00050000, 32'h00010000, 32'h00020000,
			32'h00000010, 32'hfffffff0, 32'h00000001, '0, '0, '0, '0);
		// A large dot product over a tiny divisor saturates the ratio.
		offer(v3au_pkg::OP_PROJ, 32'h7fffffff, '0, '0, 32'h00000100, '0, '0,
			'0, '0, '0, '0);
		offer(v3au_pkg::OP_DIST, 32'h00010000, 32'h00010000, '0,
			32'h00040000, 32'h00050000, '0, '0, '0, '0, '0);
		// Component differences past the range make the distance saturate.
		offer(v3au_pkg::OP_DIST, 32'h7fffffff, '0, '0, 32'h80000000, '0, '0,
			'0, '0, '0, '0);
		offer(v3au_pkg::OP_DIST, 32'h80000000, '0, '0, 32'h00000000, '0, '0,
			'0, '0, '0, '0);
		offer(v3au_pkg::OP_TRIPLE, 32'h00010000, '0, '0, '0, 32'h00010000, '0,
			'0, '0, 32'h00010000, '0);
		offer(v3au_pkg::OP_TRIPLE, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h80000000, '0);
		offer(v3au_pkg::OP_EQUAL, 32'h12345678, 32'h80000000, 32'h7fffffff,
			32'h12345678, 32'h80000000, 32'h7fffffff, '0, '0, '0, '0);
		offer(v3au_pkg::OP_EQUAL, 32'h12345678, 32'h80000000, 32'h7fffffff,
			32'h12345678, 32'h80000000, 32'h7ffffffe, '0, '0, '0, '0);
		offer(4'd11, 32'h00010000, 32'h00010000, 32'h00010000,
			32'h00010000, 32'h00010000, 32'h00010000, '0, '0, '0, 32'h00010000);
		offer(4'd15, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
		// The sender pauses here until every directed result has come back.
		drain();

		// Back to back, with one long receiver hold-off partway through while
		// the sender keeps offering, so the pipeline fills and stalls its input.
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (i == 40)
				hold_request = 1;
			offer_random();
		end
		drain();

		send_idle_pct = 86;
		recv_stall_pct = 0;
		for (int i = 0; i < PHASE_ITEMS; i++)
			offer_random();
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 86;
		for (int i = 0; i < PHASE_ITEMS; i++)
			offer_random();
		drain();

		send_idle_pct = 26;
		recv_stall_pct = 26;
		for (int i = 0; i < PHASE_ITEMS; i++)
			offer_random();
		drain();

		// Let a stray late result show up before the verdict.
		repeat (80) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/v3au_pkg.sv
rtl/vector3_arithmetic_unit.sv
sim/v3au_checker.sv
sim/tb_vector3_arithmetic_unit.sv
